// ===== rtl/core/kfa_pkg.sv =====
// ----------------------------------------------------------------------------
// kfa_pkg
// Types and constants shared by the keyframe animation interpolator.
// ----------------------------------------------------------------------------
package kfa_pkg;

    // Default depth of the easing frame table
    localparam int unsigned MAX_FRAMES_DEF = 256;

    // Item kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET = 2'd0;
    localparam logic [1:0] CFG_ITER   = 2'd1;
    localparam logic [1:0] CFG_FRAMES = 2'd2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Iteration count that repeats forever
    localparam logic [15:0] ITER_FOREVER = 16'hFFFF;
    localparam logic [15:0] LOOP_MAX     = 16'hFFFF;

    // One frame is 16 ms = 16e6 ns = 2^10 * 15625.
    // floor(x / 16e6) = ((x >> 10) * RECIP) >> RECIP_SHIFT, exact for x >> 10 < 2^26.
    localparam int unsigned FRAME_NS     = 16_000_000;
    localparam int unsigned FRAME_NS_W   = 24;
    localparam int unsigned DIV_PRESHIFT = 10;
    localparam int unsigned RECIP_W      = 28;
    localparam logic [RECIP_W-1:0] RECIP = 28'd140737489;
    localparam int unsigned RECIP_SHIFT  = 41;

    // Fixed point
    localparam int unsigned WEIGHT_FRAC = 14;

    typedef struct packed {
        logic               mode;
        logic [7:0]         frame_index_in;
        logic signed [15:0] frame_weight;
        logic [63:0]        frame_time_ns;
        logic signed [31:0] current_value;
        logic               node_present;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] next_value;
        logic               done_res;
    } t_out_item;

endpackage

// ===== rtl/core/kfa_ram.sv =====
// ----------------------------------------------------------------------------
// kfa_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kfa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/keyframe_animation_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_animation_interpolator
// A tick result is registered through the datapath stages and the output
// register. Throughput: one beat per cycle while the output side is not
// stalled; a load right behind a tick is held off until that tick has read
// the frame table RAM, longer while the result side is stalled.
// Reset (synchronous, active low) resets the run state, the pipeline valid
// flags and the config registers; the frame table RAM holds no defined data until written.
// ----------------------------------------------------------------------------
module keyframe_animation_interpolator #(
    parameter int unsigned MAX_FRAMES = kfa_pkg::MAX_FRAMES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // config
    input  logic                             i_cfg_we,
    input  logic [kfa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kfa_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  kfa_pkg::t_in_item                i_in_data,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output kfa_pkg::t_out_item               o_out_data
);

    localparam int unsigned IDX_W  = $clog2(MAX_FRAMES);
    localparam int unsigned THR_W  = IDX_W + kfa_pkg::FRAME_NS_W;
    localparam int unsigned EQ_W   = THR_W - kfa_pkg::DIV_PRESHIFT;
    localparam int unsigned QP_W   = EQ_W + kfa_pkg::RECIP_W;
    localparam int unsigned FI_W   = IDX_W + 8;

    // ---------------- configuration ----------------
    logic signed [31:0] r_target;
    logic signed [15:0] r_iter;
    logic [THR_W-1:0]   r_thresh;   // (frames - 1) * 16 ms in ns

    logic [31:0]        cfg_fc;
    logic [IDX_W-1:0]   cfg_last;
    logic [THR_W-1:0]   cfg_thresh;

    always_comb begin
        cfg_fc = {23'd0, i_cfg_data[8:0]};
        if (cfg_fc == 32'd0) begin
            cfg_fc = 32'd1;
        end else if (cfg_fc > 32'(MAX_FRAMES)) begin
            cfg_fc = 32'(MAX_FRAMES);
        end
        cfg_last   = IDX_W'(cfg_fc - 32'd1);
        cfg_thresh = THR_W'(cfg_last) * THR_W'(kfa_pkg::FRAME_NS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_iter   <= 16'sd1;
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                kfa_pkg::CFG_TARGET: r_target <= i_cfg_data;
                kfa_pkg::CFG_ITER:   r_iter   <= i_cfg_data[15:0];
                kfa_pkg::CFG_FRAMES: r_thresh <= cfg_thresh;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic r_last1, r_last2, r_last3, r_last4;
    logic r_done1, r_done2, r_done3, r_done4;
    logic en1, en2, en3, en4, en_out;
    logic rd_pend, accept, is_load, tick_res;

    assign en_out = !r_out_valid || !i_out_stall;
    assign en4    = !r_v4 || en_out;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;

    // a load must not overwrite the table ahead of an older tick's read
    assign rd_pend    = (r_v1 && !r_last1) || (r_v2 && !r_last2);
    assign is_load    = (i_in_data.mode == kfa_pkg::MODE_LOAD);
    assign o_in_stall = !en1 || (is_load && rd_pend);
    assign accept     = i_in_valid && !o_in_stall;

    // ---------------- run state ----------------
    logic [63:0]        r_start_time, n_start_time;
    logic               r_start_valid, n_start_valid;
    logic signed [31:0] r_start_value, n_start_value;
    logic [15:0]        r_loop, n_loop;
    logic               r_finished, n_finished;

    logic [63:0]        st_eff;
    logic [63:0]        elapsed;
    logic               at_last;
    logic               loop_on;
    logic               tick_done;

    always_comb begin
        n_start_time  = r_start_time;
        n_start_valid = r_start_valid;
        n_start_value = r_start_value;
        n_loop        = r_loop;
        n_finished    = r_finished;
        tick_res      = 1'b0;
        tick_done     = 1'b0;

        st_eff  = r_start_valid ? r_start_time : i_in_data.frame_time_ns;
        elapsed = i_in_data.frame_time_ns - st_eff;
        at_last = (elapsed >= 64'(r_thresh));
        loop_on = (r_iter == kfa_pkg::ITER_FOREVER) ||
                  ($signed({1'b0, r_loop}) < $signed({r_iter[15], r_iter}));

        if (accept) begin
            if (is_load) begin
                n_loop        = 16'd1;
                n_start_valid = 1'b0;
                n_start_time  = '0;
                n_finished    = (r_iter == 16'sd0);
            end else if (!r_finished) begin
                if (!i_in_data.node_present) begin
                    n_finished = 1'b1;
                end else begin
                    tick_res = 1'b1;
                    if (!r_start_valid) begin
                        n_start_time = i_in_data.frame_time_ns;
                        if (r_loop == 16'd1) begin
                            n_start_value = i_in_data.current_value;
                        end
                    end
                    if (at_last) begin
                        if (loop_on) begin
                            n_start_valid = 1'b0;
                            if (r_loop != kfa_pkg::LOOP_MAX) begin
                                n_loop = r_loop + 16'd1;
                            end
                        end else begin
                            n_start_valid = 1'b1;
                            n_finished    = 1'b1;
                            tick_done     = 1'b1;
                        end
                    end else begin
                        n_start_valid = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time  <= '0;
            r_start_valid <= 1'b0;
            r_start_value <= '0;
            r_loop        <= 16'd1;
            r_finished    <= 1'b0;
        end else begin
            r_start_time  <= n_start_time;
            r_start_valid <= n_start_valid;
            r_start_value <= n_start_value;
            r_loop        <= n_loop;
            r_finished    <= n_finished;
        end
    end

    // ---------------- frame table ----------------
    logic [FI_W-1:0]  fi_ext;
    logic             tbl_we;
    logic [15:0]      tbl_rdata;
    logic [IDX_W-1:0] r_idx2;

    assign fi_ext = FI_W'(i_in_data.frame_index_in);
    assign tbl_we = accept && is_load && (fi_ext < FI_W'(MAX_FRAMES));

    kfa_ram #(
        .WIDTH (16),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (fi_ext[IDX_W-1:0]),
        .i_wdata (i_in_data.frame_weight),
        .i_re    (en3),
        .i_raddr (r_idx2),
        .o_rdata (tbl_rdata)
    );

    // ---------------- datapath stages ----------------
    logic [EQ_W-1:0]    r_eq1;
    logic signed [32:0] r_diff1, r_diff2, r_diff3;
    logic signed [31:0] r_stv1, r_stv2, r_stv3, r_stv4;
    logic signed [31:0] stv_eff;
    logic signed [48:0] wprod;
    logic signed [48:0] r_prod4;
    logic signed [34:0] shifted;
    logic signed [35:0] sum;
    logic signed [31:0] sat_val;
    kfa_pkg::t_out_item r_out;

    assign stv_eff = n_start_value;

    // elapsed is below the threshold (< 2^THR_W) whenever the quotient is used
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_eq1   <= elapsed[THR_W-1:kfa_pkg::DIV_PRESHIFT];
            r_diff1 <= {r_target[31], r_target} - {stv_eff[31], stv_eff};
            r_stv1  <= stv_eff;
            r_last1 <= at_last;
            r_done1 <= tick_done;
        end
    end

    logic [QP_W-1:0] qprod1;
    assign qprod1 = QP_W'(r_eq1) * QP_W'(kfa_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_idx2  <= qprod1[kfa_pkg::RECIP_SHIFT +: IDX_W];
            r_diff2 <= r_diff1;
            r_stv2  <= r_stv1;
            r_last2 <= r_last1;
            r_done2 <= r_done1;
        end
        if (en3) begin
            r_diff3 <= r_diff2;
            r_stv3  <= r_stv2;
            r_last3 <= r_last2;
            r_done3 <= r_done2;
        end
        if (en4) begin
            r_prod4 <= wprod;
            r_stv4  <= r_stv3;
            r_last4 <= r_last3;
            r_done4 <= r_done3;
        end
        if (en_out && r_v4) begin
            r_out.next_value <= r_last4 ? r_target : sat_val;
            r_out.done_res   <= r_done4;
        end
    end

    // 33 x 16 signed product, sign-extended into the 49-bit result
    assign wprod   = r_diff3 * $signed(tbl_rdata);
    assign shifted = r_prod4[48:kfa_pkg::WEIGHT_FRAC];   // floor shift
    assign sum     = {{4{r_stv4[31]}}, r_stv4} + {shifted[34], shifted};

    always_comb begin
        if (sum[35:31] == 5'b00000 || sum[35:31] == 5'b11111) begin
            sat_val = sum[31:0];
        end else if (sum[35]) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1)    r_v1        <= tick_res;
            if (en2)    r_v2        <= r_v1;
            if (en3)    r_v3        <= r_v2;
            if (en4)    r_v4        <= r_v3;
            if (en_out) r_out_valid <= r_v4;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
